// ----- hdl/mcer_pkg.sv -----
// Shared constants, codes, types and address helpers for the event ring pool.
package mcer_pkg;

   // Pool geometry
   localparam int CHANNELS = 16;
   localparam int DEPTH    = 64;
   localparam int WAITERS  = 8;

   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PTR_W    = $clog2(DEPTH);
   localparam int WIDX_W   = (WAITERS > 1) ? $clog2(WAITERS) : 1;
   localparam int WCNT_W   = $clog2(WAITERS + 1);
   localparam int RING_AW  = $clog2(CHANNELS * DEPTH);
   localparam int WAIT_AW  = (CHANNELS * WAITERS > 1) ? $clog2(CHANNELS * WAITERS) : 1;

   // Request codes
   typedef enum logic [2:0] {
      REQ_CREATE  = 3'd0,
      REQ_DESTROY = 3'd1,
      REQ_PUSH    = 3'd2,
      REQ_POP     = 3'd3,
      REQ_WAIT    = 3'd4
   } req_kind_type;

   // Response status codes
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_INACTIVE  = 3'd2,
      ST_NO_FREE   = 3'd3,
      ST_WAIT_REG  = 3'd4,
      ST_WAIT_FULL = 3'd5
   } status_type;

   // Result of the free channel search
   typedef struct packed {
      logic                found;
      logic [CH_IDX_W-1:0] idx;
   } free_type;

   // Next ring position with wrap
   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (int'(p) == DEPTH - 1) ? '0 : p + PTR_W'(1);
   endfunction

   // Word address of a ring slot
   function automatic logic [RING_AW-1:0] ring_addr_f(input logic [CH_IDX_W-1:0] ch,
                                                      input logic [PTR_W-1:0]    p);
      return RING_AW'(int'(ch) * DEPTH + int'(p));
   endfunction

   // Address of a waiter slot
   function automatic logic [WAIT_AW-1:0] wait_addr_f(input logic [CH_IDX_W-1:0] ch,
                                                      input logic [WIDX_W-1:0]   i);
      return WAIT_AW'(int'(ch) * WAITERS + int'(i));
   endfunction

endpackage

// ----- hdl/mcer_free_find.sv -----
// Lowest inactive channel search for create requests.
module mcer_free_find import mcer_pkg::*; (
   input  logic [CHANNELS-1:0] active,
   output free_type            free
);

   // Scan from the top down so the lowest free index wins
   always_comb begin
      free = '0;
      for (int i = CHANNELS - 1; i >= 0; i--) begin
         if (!active[i]) begin
            free.found = 1'b1;
            free.idx   = CH_IDX_W'(i);
         end
      end
   end

endmodule

// ----- hdl/multi_channel_event_ring.sv -----
// Top level of the event channel pool: request sequencer, descriptors and memories.
//
// A pool of 16 event channels, each a 64-word ring (63 usable, the oldest word is
// dropped on overflow) plus a list of up to 8 waiting thread ids. One request is
// worked on at a time. Create, destroy or push with no waiters, empty pop and wait
// requests pass through the accept and execute states. Pop or wait that returns a
// word also passes through a read state, because the ring word memory has a
// registered read. Push or destroy that releases waiters reads each waiter id from
// the waiter memory and then presents it as its own response. A finished response
// sits in an output register, so the next request is accepted while it waits.
// The word and waiter memories are not cleared after reset; only entries that were
// written are ever read, so the block takes requests as soon as reset is released.
module multi_channel_event_ring import mcer_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [3:0]  req_channel,
   input  logic [31:0] req_event_data,
   input  logic [7:0]  req_requester_tid,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_channel_out,
   output logic [31:0] rsp_data,
   output logic        rsp_wake_valid,
   output logic [7:0]  rsp_wake_tid,
   output logic        rsp_last
);

   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_EXEC     = 5'b00010,
      S_READ     = 5'b00100,
      S_WAKE_RD  = 5'b01000,
      S_WAKE_OUT = 5'b10000
   } state_type;

   state_type           state_ff, state_in;

   // Captured request
   logic [2:0]          req_kind_ff;
   logic [3:0]          req_ch_ff;
   logic [31:0]         req_word_ff;
   logic [7:0]          req_tid_ff;

   // Channel descriptors
   logic [CHANNELS-1:0] active_ff, active_in;
   logic [PTR_W-1:0]    head_ff [CHANNELS];
   logic [PTR_W-1:0]    tail_ff [CHANNELS];
   logic [WCNT_W-1:0]   wcnt_ff [CHANNELS];
   logic                desc_we;
   logic [CH_IDX_W-1:0] desc_idx;
   logic [PTR_W-1:0]    desc_head_in, desc_tail_in;
   logic [WCNT_W-1:0]   desc_wcnt_in;

   // Waiter release walk
   logic [WCNT_W-1:0]   wake_n_ff, wake_n_in;
   logic [WCNT_W-1:0]   wake_i_ff, wake_i_in;
   logic [WCNT_W-1:0]   wake_nxt;

   // Memories
   logic [31:0]         ring_mem [CHANNELS*DEPTH];
   logic [31:0]         ring_rd_ff;
   logic                ring_we, ring_re;
   logic [RING_AW-1:0]  ring_addr;
   logic [7:0]          wait_mem [CHANNELS*WAITERS];
   logic [7:0]          wait_rd_ff;
   logic                wait_we, wait_re;
   logic [WAIT_AW-1:0]  wait_addr;

   // Response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          rsp_status_ff;
   logic [3:0]          rsp_chan_ff;
   logic [31:0]         rsp_data_ff;
   logic                rsp_wv_ff;
   logic [7:0]          rsp_tid_ff;
   logic                rsp_last_ff;
   logic                out_free, out_load;
   logic [2:0]          out_status;
   logic [3:0]          out_chan;
   logic [31:0]         out_data;
   logic                out_wv;
   logic [7:0]          out_tid;
   logic                out_last;

   // Decode of the current channel
   logic [CH_IDX_W-1:0] ch_idx;
   logic                ch_act;
   logic [PTR_W-1:0]    cur_head, cur_tail, nxt_head;
   logic [WCNT_W-1:0]   cur_wcnt;
   logic                do_release;
   free_type            free;

   mcer_free_find u_free_find (
      .active (active_ff),
      .free   (free)
   );

   assign ch_idx   = CH_IDX_W'(req_ch_ff);
   assign ch_act   = (int'(req_ch_ff) < CHANNELS) && active_ff[ch_idx];
   assign cur_head = head_ff[ch_idx];
   assign cur_tail = tail_ff[ch_idx];
   assign cur_wcnt = wcnt_ff[ch_idx];
   assign nxt_head = ptr_next(cur_head);
   assign wake_nxt = wake_i_ff + WCNT_W'(1);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign req_stall = (state_ff != S_IDLE);

   // Request sequencer
   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      desc_we      = 1'b0;
      desc_idx     = ch_idx;
      desc_head_in = cur_head;
      desc_tail_in = cur_tail;
      desc_wcnt_in = cur_wcnt;
      wake_n_in    = wake_n_ff;
      wake_i_in    = wake_i_ff;
      ring_we      = 1'b0;
      ring_re      = 1'b0;
      ring_addr    = ring_addr_f(ch_idx, cur_head);
      wait_we      = 1'b0;
      wait_re      = 1'b0;
      wait_addr    = wait_addr_f(ch_idx, WIDX_W'(cur_wcnt));
      do_release   = 1'b0;
      out_load     = 1'b0;
      out_status   = ST_OK;
      out_chan     = '0;
      out_data     = '0;
      out_wv       = 1'b0;
      out_tid      = '0;
      out_last     = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            if (out_free) begin
               state_in = S_IDLE;
               case (req_kind_ff)
                  REQ_CREATE: begin
                     out_load = 1'b1;
                     if (free.found) begin
                        active_in[free.idx] = 1'b1;
                        desc_we      = 1'b1;
                        desc_idx     = free.idx;
                        desc_head_in = '0;
                        desc_tail_in = '0;
                        desc_wcnt_in = '0;
                        out_chan     = 4'(free.idx);
                     end else begin
                        out_status = ST_NO_FREE;
                     end
                  end
                  REQ_DESTROY: begin
                     if (!ch_act) begin
                        out_load   = 1'b1;
                        out_status = ST_INACTIVE;
                     end else begin
                        active_in[ch_idx] = 1'b0;
                        desc_we      = 1'b1;
                        desc_wcnt_in = '0;
                        do_release   = 1'b1;
                     end
                  end
                  REQ_PUSH: begin
                     if (!ch_act) begin
                        out_load   = 1'b1;
                        out_status = ST_INACTIVE;
                     end else begin
                        // Overwrite: a full ring drops its oldest word
                        ring_we      = 1'b1;
                        desc_we      = 1'b1;
                        desc_head_in = nxt_head;
                        desc_tail_in = (nxt_head == cur_tail) ? ptr_next(cur_tail) : cur_tail;
                        desc_wcnt_in = '0;
                        do_release   = 1'b1;
                     end
                  end
                  REQ_POP, REQ_WAIT: begin
                     if (!ch_act) begin
                        out_load   = 1'b1;
                        out_status = ST_INACTIVE;
                     end else if (cur_head != cur_tail) begin
                        ring_re      = 1'b1;
                        ring_addr    = ring_addr_f(ch_idx, cur_tail);
                        desc_we      = 1'b1;
                        desc_tail_in = ptr_next(cur_tail);
                        state_in     = S_READ;
                     end else if (req_kind_ff == REQ_POP) begin
                        out_load   = 1'b1;
                        out_status = ST_EMPTY;
                     end else if (cur_wcnt < WCNT_W'(WAITERS)) begin
                        wait_we      = 1'b1;
                        desc_we      = 1'b1;
                        desc_wcnt_in = cur_wcnt + WCNT_W'(1);
                        out_load     = 1'b1;
                        out_status   = ST_WAIT_REG;
                     end else begin
                        out_load   = 1'b1;
                        out_status = ST_WAIT_FULL;
                     end
                  end
                  default: begin
                     out_load   = 1'b1;
                     out_status = ST_INACTIVE;
                  end
               endcase

               // Release: one empty response, or walk the waiter list
               if (do_release) begin
                  if (cur_wcnt == '0) begin
                     out_load = 1'b1;
                  end else begin
                     wake_n_in = cur_wcnt;
                     wake_i_in = '0;
                     state_in  = S_WAKE_RD;
                  end
               end
            end
         end

         S_READ: begin
            if (out_free) begin
               out_load = 1'b1;
               out_data = ring_rd_ff;
               state_in = S_IDLE;
            end
         end

         S_WAKE_RD: begin
            wait_re   = 1'b1;
            wait_addr = wait_addr_f(ch_idx, WIDX_W'(wake_i_ff));
            state_in  = S_WAKE_OUT;
         end

         S_WAKE_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               out_wv   = 1'b1;
               out_tid  = wait_rd_ff;
               out_last = (wake_nxt == wake_n_ff);
               if (wake_nxt == wake_n_ff) begin
                  state_in = S_IDLE;
               end else begin
                  wake_i_in = wake_nxt;
                  state_in  = S_WAKE_RD;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         wake_n_ff    <= '0;
         wake_i_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         wake_n_ff    <= wake_n_in;
         wake_i_ff    <= wake_i_in;
      end
   end

   // Request capture, descriptors and response payload
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_kind_ff <= req_type;
         req_ch_ff   <= req_channel;
         req_word_ff <= req_event_data;
         req_tid_ff  <= req_requester_tid;
      end
      if (desc_we) begin
         head_ff[desc_idx] <= desc_head_in;
         tail_ff[desc_idx] <= desc_tail_in;
         wcnt_ff[desc_idx] <= desc_wcnt_in;
      end
      if (out_load) begin
         rsp_status_ff <= out_status;
         rsp_chan_ff   <= out_chan;
         rsp_data_ff   <= out_data;
         rsp_wv_ff     <= out_wv;
         rsp_tid_ff    <= out_tid;
         rsp_last_ff   <= out_last;
      end
   end

   // Ring word memory
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_addr] <= req_word_ff;
      end
      if (ring_re) begin
         ring_rd_ff <= ring_mem[ring_addr];
      end
   end

   // Waiter id memory
   always_ff @(posedge clock) begin
      if (wait_we) begin
         wait_mem[wait_addr] <= req_tid_ff;
      end
      if (wait_re) begin
         wait_rd_ff <= wait_mem[wait_addr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_channel_out = rsp_chan_ff;
   assign rsp_data        = rsp_data_ff;
   assign rsp_wake_valid  = rsp_wv_ff;
   assign rsp_wake_tid    = rsp_tid_ff;
   assign rsp_last        = rsp_last_ff;

   // An accepted request moves the sequencer to the execute state in the next cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == S_EXEC)
      else $error("accepted request not executed");

   // The waiter walk never runs past the captured count
   a_wake_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAKE_RD || state_ff == S_WAKE_OUT) |-> wake_i_ff < wake_n_ff)
      else $error("waiter walk out of range");

   // A new response only comes out of a busy sequencer
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff != S_IDLE))
      else $error("response without a request in progress");

   // Released waiters always carry ok status
   a_wake_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_wv_ff |-> rsp_status_ff == ST_OK)
      else $error("wake response with bad status");

   // An active channel never holds more waiters than its list
   a_wcnt_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXEC && ch_act |-> cur_wcnt <= WCNT_W'(WAITERS))
      else $error("waiter count overflow");

endmodule
